FILE: hw/rtl/frame_rms_meter_with_pcm16_convert_assert.svh
// Assertion macros for the frame RMS meter checker.
// Included by the checker file; defines nothing else.
`ifndef FRAME_RMS_METER_WITH_PCM16_CONVERT_ASSERT_SVH
`define FRAME_RMS_METER_WITH_PCM16_CONVERT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FRMS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FRMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/frms_pkg.sv
// Shared widths, constants and control types of the frame RMS meter.
// No dependencies; every other RTL file but the assertion macro header imports it.
package frms_pkg;

  localparam int unsigned SAMPLE_W      = 24;
  localparam int unsigned PCM_W         = 16;
  localparam int unsigned LEVEL_W       = 16;
  localparam int unsigned SUM_W         = 59;
  localparam int unsigned SQ_W          = 47;
  localparam int unsigned FRAC_SHIFT    = 12;
  localparam int unsigned QUO_W         = SUM_W - FRAC_SHIFT;
  localparam int unsigned RAD_W         = 2 * LEVEL_W;
  localparam int unsigned ROOT_W        = LEVEL_W;
  localparam int unsigned CLAMP_W       = 21;
  localparam int unsigned Q_SHIFT       = 20;
  localparam int unsigned SCALE_SHIFT   = 15;
  localparam int unsigned SCALED_W      = CLAMP_W + SCALE_SHIFT;
  localparam int unsigned DIV_STEPS     = QUO_W;
  localparam int unsigned SQRT_STEPS    = RAD_W / 2;
  localparam int unsigned STEP_W        = $clog2(DIV_STEPS);
  localparam int unsigned DEF_MAX_FRAME = 4096;

  localparam logic [CLAMP_W-1:0] ONE_Q20 = CLAMP_W'(1) << Q_SHIFT;

  typedef struct packed {
    logic load_in;
    logic acc;
    logic div_step;
    logic sqrt_step;
    logic out_load;
    logic out_lvl;
  } frms_cmd_t;

  typedef struct packed {
    logic close;
    logic out_free;
  } frms_stat_t;

endpackage

FILE: hw/rtl/frms_in_if.sv
// Input channel of the frame RMS meter: one sample beat with its frame mark.
// Depends on frms_pkg for the sample width.
interface frms_in_if;
  import frms_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_in_frame;

  modport source (output valid, sample, last_in_frame, input ready);
  modport sink   (input valid, sample, last_in_frame, output ready);
endinterface

FILE: hw/rtl/frms_out_if.sv
// Result channel of the frame RMS meter: PCM sample plus optional frame level.
// Depends on frms_pkg for the field widths.
interface frms_out_if;
  import frms_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [PCM_W-1:0] pcm_sample;
  logic [LEVEL_W-1:0]      level;
  logic                    level_valid;

  modport source (output valid, pcm_sample, level, level_valid, input ready);
  modport sink   (input valid, pcm_sample, level, level_valid, output ready);
endinterface

FILE: hw/rtl/frms_ctrl.sv
// Sequencer of the frame RMS meter: accept, accumulate, divide, root, emit.
// Depends on frms_pkg for the command and status structs.
module frms_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  frms_pkg::frms_stat_t stat,
  output frms_pkg::frms_cmd_t  cmd
);
  import frms_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ACC  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_SQRT = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              closed_r, closed_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    closed_nxt = closed_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        closed_nxt = stat.close;
        step_nxt   = '0;
        if (stat.close) begin
          state_nxt = S_DIV;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_SQRT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
          step_nxt  = '0;
          state_nxt = S_EMIT;
        end else begin
          step_nxt = step_r + STEP_W'(1);
        end
      end
      S_EMIT: begin
        cmd.out_lvl = closed_r;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      step_r   <= '0;
      closed_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      step_r   <= step_nxt;
      closed_r <= closed_nxt;
    end
  end
endmodule

FILE: hw/rtl/frms_dp.sv
// Datapath of the frame RMS meter: PCM conversion, square accumulation,
// bit-serial divider, digit-serial square root and output register.
// Depends on frms_pkg; driven by frms_ctrl through frms_cmd_t.
module frms_dp #(
  parameter int unsigned MAX_FRAME = frms_pkg::DEF_MAX_FRAME
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  frms_pkg::frms_cmd_t                  cmd,
  output frms_pkg::frms_stat_t                 stat,
  input  logic signed [frms_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                 in_last,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic signed [frms_pkg::PCM_W-1:0]    out_pcm_sample,
  output logic [frms_pkg::LEVEL_W-1:0]         out_level,
  output logic                                 out_level_valid
);
  import frms_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_FRAME + 1);

  // input stage
  logic                    neg;
  logic [SAMPLE_W-1:0]     mag;
  logic [CLAMP_W-1:0]      cmag;
  logic [SCALED_W-1:0]     scaled;
  logic [PCM_W-1:0]        pmag;
  logic [2*SAMPLE_W-1:0]   prod;
  logic [SQ_W-1:0]         sq_r;
  logic signed [PCM_W-1:0] pcm_r;
  logic                    last_r;

  // accumulation
  logic [SUM_W-1:0] sum_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W:0]   sum_add;
  logic [SUM_W-1:0] sum_sat;
  logic [CNT_W-1:0] cnt_inc;

  // divider and root
  logic [QUO_W-1:0]    quo_r;
  logic [CNT_W-1:0]    div_r;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W:0]      rem_sh;
  logic                rem_ge;
  logic [ROOT_W-1:0]   root_r;
  logic [ROOT_W:0]     srem_r;
  logic [ROOT_W+2:0]   srem_sh;
  logic [ROOT_W+2:0]   trial;
  logic                srem_ge;
  logic                lvl_sat;

  // output register
  logic                    out_valid_r;
  logic signed [PCM_W-1:0] out_pcm_r;
  logic [LEVEL_W-1:0]      out_level_r;
  logic                    out_lvl_r;

  // clamp to +-1.0, scale by 32767 on the magnitude, truncate toward zero
  always_comb begin
    neg    = in_sample[SAMPLE_W-1];
    mag    = neg ? (~in_sample + SAMPLE_W'(1)) : in_sample;
    cmag   = (mag > SAMPLE_W'(ONE_Q20)) ? ONE_Q20 : mag[CLAMP_W-1:0];
    scaled = {cmag, SCALE_SHIFT'(0)} - SCALED_W'(cmag);
    pmag   = scaled[SCALED_W-1 -: PCM_W];
    prod   = mag * mag;
  end

  assign sum_add = {1'b0, sum_r} + (SUM_W + 1)'(sq_r);
  assign sum_sat = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
  assign cnt_inc = cnt_r + CNT_W'(1);

  assign stat.close    = last_r || (cnt_inc >= CNT_W'(MAX_FRAME));
  assign stat.out_free = !out_valid_r || out_ready;

  assign rem_sh  = {rem_r, quo_r[QUO_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, div_r};
  assign srem_sh = {srem_r, quo_r[RAD_W-1 -: 2]};
  assign trial   = (ROOT_W + 3)'({root_r, 2'b01});
  assign srem_ge = srem_sh >= trial;
  assign lvl_sat = |quo_r[QUO_W-1:RAD_W];

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sq_r   <= prod[SQ_W-1:0];
      pcm_r  <= neg ? -$signed(pmag) : $signed(pmag);
      last_r <= in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else if (cmd.acc) begin
      if (stat.close) begin
        sum_r <= '0;
        cnt_r <= '0;
      end else begin
        sum_r <= sum_sat;
        cnt_r <= cnt_inc;
      end
    end
  end

  // divide (sum >> 12) by count one quotient bit a cycle, then take the root
  // of the low 32 quotient bits two radicand bits a cycle; the upper bits hold
  always_ff @(posedge clk) begin
    if (cmd.acc && stat.close) begin
      quo_r  <= sum_sat[SUM_W-1:FRAC_SHIFT];
      div_r  <= cnt_inc;
      rem_r  <= '0;
      root_r <= '0;
      srem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? CNT_W'(rem_sh - {1'b0, div_r}) : rem_sh[CNT_W-1:0];
      quo_r <= {quo_r[QUO_W-2:0], rem_ge};
    end else if (cmd.sqrt_step) begin
      srem_r <= srem_ge ? (ROOT_W + 1)'(srem_sh - trial) : srem_sh[ROOT_W:0];
      root_r <= {root_r[ROOT_W-2:0], srem_ge};
      quo_r  <= {quo_r[QUO_W-1:RAD_W], quo_r[RAD_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pcm_r   <= pcm_r;
      out_lvl_r   <= cmd.out_lvl;
      out_level_r <= !cmd.out_lvl ? '0 : (lvl_sat ? {LEVEL_W{1'b1}} : root_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pcm_sample  = out_pcm_r;
  assign out_level       = out_level_r;
  assign out_level_valid = out_lvl_r;
endmodule

FILE: hw/rtl/frame_rms_meter_with_pcm16_convert.sv
// Frame RMS level meter with 16-bit PCM conversion. Every input beat (a signed
// Q3.20 sample and an end-of-frame mark) yields exactly one result beat: the
// sample clamped to [-1, 1], scaled by 32767 and truncated toward zero, and,
// on the beat that closes a frame, the frame RMS sqrt(sum of squares / count)
// in unsigned Q2.14, truncated and saturated to 65535 (level is zero on other
// beats). A frame closes on the marked sample or when it reaches MAX_FRAME
// samples. The square sum is kept on the unclamped samples and saturates.
// One sample is in work at a time. A sample that does not close a frame
// is accepted, then accumulated, and loads the output register once that is
// free. A closing sample is accepted, accumulated, run through the
// bit-serial divider (one quotient bit per cycle over the 47-bit scaled sum)
// and the digit-serial square root, and then loads the result. The
// next sample is accepted while a finished result still waits in the output
// register; a stalled output holds the block only once the next result is
// ready. Depends on frms_pkg, frms_in_if, frms_out_if, frms_ctrl and frms_dp.
module frame_rms_meter_with_pcm16_convert #(
  parameter int unsigned MAX_FRAME = frms_pkg::DEF_MAX_FRAME
) (
  input logic        clk,
  input logic        rst_n,
  frms_in_if.sink    in_ch,
  frms_out_if.source out_ch
);
  import frms_pkg::*;

  frms_cmd_t  cmd;
  frms_stat_t stat;

  // sequencer: owns the state and the divide/root step counter
  frms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: conversion, accumulation, divide, root and output register
  frms_dp #(
    .MAX_FRAME (MAX_FRAME)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_sample       (in_ch.sample),
    .in_last         (in_ch.last_in_frame),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_pcm_sample  (out_ch.pcm_sample),
    .out_level       (out_ch.level),
    .out_level_valid (out_ch.level_valid)
  );
endmodule

FILE: hw/rtl/frms_checker.sv
// Port-level checks of the frame RMS meter, bound to the top level.
// Depends on frms_pkg and the assertion macro header.
`include "frame_rms_meter_with_pcm16_convert_assert.svh"

module frms_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_ready,
  input logic                                 out_valid,
  input logic                                 out_ready,
  input logic signed [frms_pkg::PCM_W-1:0]    out_pcm_sample,
  input logic [frms_pkg::LEVEL_W-1:0]         out_level,
  input logic                                 out_level_valid
);
  import frms_pkg::*;

  // one sample in work: no beat is taken right after another
  `FRMS_ASSERT_NEXT(a_one_in_work, clk, rst_n, in_valid && in_ready, !in_ready, "back-to-back accept")
  // level is zero unless the beat closes a frame
  `FRMS_ASSERT_SAME(a_level_zero, clk, rst_n, out_valid && !out_level_valid, out_level == '0, "stray level")
  // clamp keeps PCM inside +-32767
  `FRMS_ASSERT_SAME(a_pcm_range, clk, rst_n, out_valid, out_pcm_sample != {1'b1, {(PCM_W-1){1'b0}}}, "PCM out of range")
  // stalled result holds
  `FRMS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pcm_sample) && $stable(out_level) && $stable(out_level_valid), "stalled result changed")
endmodule

bind frame_rms_meter_with_pcm16_convert frms_checker u_frms_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_pcm_sample  (out_ch.pcm_sample),
  .out_level       (out_ch.level),
  .out_level_valid (out_ch.level_valid)
);

FILE: dv/tb_top.sv
// Self-checking bench for the frame RMS meter: random framed samples against an in-bench predictor.
// Depends on frms_pkg, frms_in_if, frms_out_if and the frame_rms_meter_with_pcm16_convert RTL.
`timescale 1ns / 1ps

module tb_top;
  import frms_pkg::*;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic signed [PCM_W-1:0] pcm;
    logic [LEVEL_W-1:0]      level;
    logic                    level_valid;
  } level_beat_t;

  localparam int unsigned FRAME_LIMIT   = DEF_MAX_FRAME;
  localparam longint      UNITY         = longint'(1) << Q_SHIFT;   // 1.0 in Q3.20
  localparam u64_t        SUM_LIMIT     = (u64_t'(1) << SUM_W) - 1;
  localparam int unsigned CYCLE_LIMIT   = 1_500_000;
  localparam int unsigned CLOSE_LATENCY = 70;
  localparam int unsigned RANDOM_ITEMS  = 1400;
  localparam int unsigned MAX_PRINTS    = 20;

  logic clk = 1'b0;
  logic rst_n;

  frms_in_if  in_ch ();
  frms_out_if out_ch ();

  frame_rms_meter_with_pcm16_convert #(
    .MAX_FRAME(FRAME_LIMIT)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 4 ns clock: two delays, high then low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ------------------------------------------------------------------
  // Predictor state: the open frame's square sum and sample count.
  // ------------------------------------------------------------------
  u64_t        frame_sq_sum;
  int unsigned frame_len;
  level_beat_t expected_beats[$];

  // Run statistics and error count.
  int unsigned mismatches;
  int unsigned samples_checked;
  int unsigned levels_checked;
  int unsigned levels_saturated;
  int unsigned full_frame_closes;
  int unsigned clamped_samples;
  int unsigned cycle_count;

  // Floor of the square root, built one result bit at a time from the top.
  function automatic u64_t floor_sqrt(u64_t n);
    u64_t root;
    u64_t trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (u64_t'(1) << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Work out the result beat for one accepted sample and advance the frame.
  function automatic level_beat_t predict_meter_beat(logic signed [SAMPLE_W-1:0] s,
                                                     logic last);
    longint      v;
    longint      clamped;
    longint      pcm;
    u64_t        mag;
    u64_t        sq;
    u64_t        quo;
    u64_t        root;
    level_beat_t r;
    v = s;
    clamped = (v > UNITY) ? UNITY : ((v < -UNITY) ? -UNITY : v);
    if (clamped != v) clamped_samples++;
    // SV signed division truncates toward zero, which is what the PCM path wants.
    pcm = (clamped * 32767) / UNITY;
    // The square sum takes the unclamped sample and saturates.
    mag = (v < 0) ? u64_t'(-v) : u64_t'(v);
    sq  = mag * mag;
    if (frame_sq_sum > SUM_LIMIT - sq) frame_sq_sum = SUM_LIMIT;
    else frame_sq_sum = frame_sq_sum + sq;
    frame_len++;
    r.pcm         = pcm[PCM_W-1:0];
    r.level       = '0;
    r.level_valid = 1'b0;
    if (last || frame_len >= FRAME_LIMIT) begin
      if (!last) full_frame_closes++;
      quo  = frame_sq_sum / (u64_t'(frame_len) << FRAC_SHIFT);
      root = floor_sqrt(quo);
      if (root > 65535) root = 65535;
      r.level       = root[LEVEL_W-1:0];
      r.level_valid = 1'b1;
      frame_sq_sum  = 0;
      frame_len     = 0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // ------------------------------------------------------------------
  // Monitors. Both sample at the falling edge: inputs change only at the
  // rising edge, so the values seen here are the ones the next rising
  // edge acts on. A beat moves when valid and ready are both high.
  // ------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      expected_beats.insert(expected_beats.size(),
                            predict_meter_beat(in_ch.sample, in_ch.last_in_frame));
  end

  level_beat_t want;

  always @(negedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending (pcm=%0d level=%0d)",
                                  out_ch.pcm_sample, out_ch.level));
      end else begin
        want = expected_beats.pop_front();
        samples_checked++;
        if (want.level_valid) begin
          levels_checked++;
          if (want.level == 16'hFFFF) levels_saturated++;
        end
        if (out_ch.pcm_sample !== want.pcm)
          report_mismatch($sformatf("beat %0d pcm_sample got %0d want %0d",
                                    samples_checked, out_ch.pcm_sample, want.pcm));
        if (out_ch.level !== want.level)
          report_mismatch($sformatf("beat %0d level got %0d want %0d",
                                    samples_checked, out_ch.level, want.level));
        if (out_ch.level_valid !== want.level_valid)
          report_mismatch($sformatf("beat %0d level_valid got %b want %b",
                                    samples_checked, out_ch.level_valid, want.level_valid));
      end
    end
  end

  // ------------------------------------------------------------------
  // Receiver. Runs phases of random length that never stall, stall now
  // and then, or stall most of the time. A test can ask for a long
  // hold-off: the request is latched here and counted down cycle by cycle.
  // ------------------------------------------------------------------
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned stall_pct;
  int unsigned phase_left;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(4, 60);
          case ($urandom_range(0, 3))
            0, 1: stall_pct = 0;
            2: stall_pct = 30;
            default: stall_pct = 75;
          endcase
        end
        phase_left = phase_left - 1;
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: end the run if it goes far past the slowest correct run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results still pending",
               cycle_count, expected_beats.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Sender. Works in bursts of random length; between bursts valid drops
  // for a random gap. Every call starts and ends in the time step of a
  // rising edge, so valid gets at most one nonblocking write per step.
  // ------------------------------------------------------------------
  int unsigned burst_left;

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s, input logic last);
    logic taken;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 20);
    end
    burst_left--;
    in_ch.valid         <= 1'b1;
    in_ch.sample        <= s;
    in_ch.last_in_frame <= last;
    // Hold the beat until the block takes it.
    do begin
      @(negedge clk);
      taken = in_ch.ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Drop valid and wait until every pending result has come back.
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
  endtask

  // Draw a sample: mostly normal audio, with clamp edges, tiny values,
  // out-of-range values and the raw 24-bit extremes mixed in.
  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = int'($urandom_range(0, 2 * UNITY)) - int'(UNITY);
      5: v = int'($urandom_range(0, 128)) - 64;
      6: v = (($urandom_range(0, 1) == 0) ? 1 : -1) * (int'(UNITY) + int'($urandom_range(0, 2)) - 1);
      7, 8: v = int'($urandom());
      default: begin
        case ($urandom_range(0, 3))
          0: v = 24'h7FFFFF;
          1: v = -8388608;
          2: v = 0;
          default: v = -1;
        endcase
      end
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // Send one frame of the given length, marking its final sample.
  task automatic send_frame(input int unsigned len);
    for (int unsigned i = 1; i <= len; i++) send_sample(random_sample(), i == len);
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // PCM conversion at the clamp edges and the raw 24-bit extremes, all in
  // one frame, then single-sample frames of exactly 1.0 and of one LSB.
  task automatic test_pcm_edges();
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd1, 1'b0);
    send_sample(-24'sd1, 1'b0);
    send_sample(24'(UNITY - 1), 1'b0);
    send_sample(24'(-(UNITY - 1)), 1'b0);
    send_sample(24'(UNITY), 1'b0);
    send_sample(24'(-UNITY), 1'b0);
    send_sample(24'(UNITY + 1), 1'b0);
    send_sample(24'(-(UNITY + 1)), 1'b0);
    send_sample(24'h7FFFFF, 1'b0);
    send_sample(24'h800000, 1'b1);
    send_sample(24'(UNITY), 1'b1);
    send_sample(24'sd1, 1'b1);
  endtask

  // A silent frame gives level zero; an RMS of 4.0 or more saturates,
  // and a hair under 4.0 truncates to the top code.
  task automatic test_loud_and_silent_frames();
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd0, 1'b0);
    send_sample(24'sd0, 1'b1);
    send_sample(24'(UNITY * 4), 1'b1);
    send_sample(24'(UNITY * 4 - 1), 1'b1);
    send_sample(24'(-UNITY * 4), 1'b1);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h800000, 1'b0);
    send_sample(24'h7FFFFF, 1'b1);
    send_sample(24'(UNITY / 2), 1'b0);
    send_sample(24'(-UNITY / 2), 1'b1);
  endtask

  // A frame with no end mark closes by itself at MAX_FRAME samples; the
  // samples after it must start a fresh frame.
  task automatic test_full_frame();
    for (int unsigned i = 0; i < FRAME_LIMIT; i++) send_sample(random_sample(), 1'b0);
    send_sample(24'(UNITY), 1'b0);
    send_sample(24'(-UNITY), 1'b1);
  endtask

  // Random frames, mostly short, now and then long. Every few hundred
  // samples the sender pauses until every pending result has come back.
  task automatic test_random_frames();
    int unsigned sent;
    int unsigned len;
    int unsigned next_pause;
    sent       = 0;
    next_pause = 300;
    while (sent < RANDOM_ITEMS) begin
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(25, 300) : $urandom_range(1, 24);
      send_frame(len);
      sent += len;
      if (sent >= next_pause) begin
        wait_for_results();
        next_pause += 300;
      end
    end
  endtask

  // Hold the result side off for a long stretch while samples keep
  // coming, so the block fills and stalls its input; then let it drain.
  task automatic test_output_stall();
    hold_request = 400;
    for (int unsigned i = 0; i < 8; i++) send_frame($urandom_range(1, 6));
    while (hold_left != 0 || hold_request != 0) @(posedge clk);
    wait_for_results();
  endtask

  initial begin
    // Known values on every input from time zero.
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.sample        = '0;
    in_ch.last_in_frame = 1'b0;
    out_ch.ready        = 1'b0;
    frame_sq_sum        = 0;
    frame_len           = 0;
    mismatches          = 0;
    samples_checked     = 0;
    levels_checked      = 0;
    levels_saturated    = 0;
    full_frame_closes   = 0;
    clamped_samples     = 0;
    cycle_count         = 0;
    hold_request        = 0;
    hold_left           = 0;
    stall_pct           = 0;
    phase_left          = 0;
    burst_left          = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pcm_edges();
    test_loud_and_silent_frames();
    test_output_stall();
    test_full_frame();
    test_random_frames();

    // Let the last closing sample finish before judging.
    wait_for_results();
    repeat (CLOSE_LATENCY) @(posedge clk);
    if (expected_beats.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_beats.size()));

    $display("Checked %0d samples (%0d clamped) and %0d frame levels in %0d cycles",
             samples_checked, clamped_samples, levels_checked, cycle_count);
    $display("Levels saturated: %0d; frames closed by length: %0d",
             levels_saturated, full_frame_closes);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
